>>> hdl/serial_command_parser_assert.svh
// Assertion macros shared by the serial command parser checkers.
`ifndef SERIAL_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/scp_pkg.sv
// Shared types and constants of the serial command parser.
`default_nettype none

package scp_pkg;

	localparam logic [7:0] CH_START = 8'h63;
	localparam logic [7:0] CH_ID_LO = 8'h31;
	localparam logic [7:0] CH_ID_HI = 8'h38;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [3:0] CMD_GEN_OFF      = 4'd1;
	localparam logic [3:0] CMD_GEN_ON       = 4'd2;
	localparam logic [3:0] CMD_FORWARD_TIME = 4'd3;
	localparam logic [3:0] CMD_REVERSE_TIME = 4'd4;
	localparam logic [3:0] CMD_DEAD_A       = 4'd5;
	localparam logic [3:0] CMD_DEAD_B       = 4'd6;
	localparam logic [3:0] CMD_FORWARD_DUTY = 4'd7;
	localparam logic [3:0] CMD_REVERSE_DUTY = 4'd8;

	localparam int unsigned QueueDepthDefault = 4;

	typedef struct packed {
		logic       done;
		logic [3:0] id;
		logic [7:0] value;
		logic       overflow;
	} cmd_rec_t;

endpackage

`default_nettype wire

>>> hdl/scp_front.sv
// Character parser: tracks the command syntax and emits one record per character.
`default_nettype none

module scp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic [7:0]       character,
	output logic                  rec_push,
	output scp_pkg::cmd_rec_t     rec
);
	import scp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ID,
		PH_FIRST,
		PH_SECOND,
		PH_THIRD,
		PH_END
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] id_q, id_d;
	logic [7:0] acc_q, acc_d;
	logic       ovf_q, ovf_d;

	logic        is_digit, is_eol, is_id;
	logic [3:0]  ch_off;
	logic [11:0] acc_x10, acc_sum;
	logic        done;

	assign rec_push = in_valid && !in_stall;

	assign ch_off   = 4'(character - CH_ZERO);
	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign is_eol   = (character == CH_LF) || (character == CH_CR);
	assign is_id    = (character >= CH_ID_LO) && (character <= CH_ID_HI);
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign acc_sum  = acc_x10 + {8'd0, ch_off[3:0]};

	always_comb begin
		phase_d = PH_IDLE;
		id_d    = 4'd0;
		acc_d   = 8'd0;
		ovf_d   = 1'b0;
		done    = 1'b0;
		rec     = '0;
		unique case (phase_q)
			PH_ID: begin
				if (is_id) begin
					phase_d = PH_FIRST;
					id_d    = ch_off[3:0];
				end
			end
			PH_FIRST: begin
				if (is_digit) begin
					phase_d = PH_SECOND;
					id_d    = id_q;
					acc_d   = {4'd0, ch_off[3:0]};
				end else if (is_eol && (id_q == CMD_GEN_OFF || id_q == CMD_GEN_ON)) begin
					done = 1'b1;
				end
			end
			PH_SECOND, PH_THIRD: begin
				if (is_digit) begin
					phase_d = (phase_q == PH_SECOND) ? PH_THIRD : PH_END;
					id_d    = id_q;
					acc_d   = acc_sum[7:0];
					ovf_d   = ovf_q || (|acc_sum[11:8]);
				end else if (is_eol) begin
					done = 1'b1;
				end
			end
			PH_END: begin
				done = is_eol;
			end
			default: begin
				if (character == CH_START) begin
					phase_d = PH_ID;
				end
			end
		endcase
		if (done) begin
			rec.done     = 1'b1;
			rec.id       = id_q;
			rec.value    = (phase_q == PH_FIRST) ? 8'd0 : acc_q;
			rec.overflow = (phase_q == PH_FIRST) ? 1'b0 : ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			id_q    <= 4'd0;
			acc_q   <= 8'd0;
			ovf_q   <= 1'b0;
		end else if (rec_push) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/scp_queue.sv
// Small register queue between the parser and the command executor.
`default_nettype none

module scp_queue #(
	parameter int unsigned DEPTH = scp_pkg::QueueDepthDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  scp_pkg::cmd_rec_t      push_data,
	output logic                   full,
	input  wire logic              pop,
	output scp_pkg::cmd_rec_t      pop_data,
	output logic                   empty
);
	import scp_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	cmd_rec_t          mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   cnt_q;

	assign full     = (cnt_q == CntW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/scp_back.sv
// Command executor: applies parsed commands to the settings and registers the result.
`default_nettype none

module scp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  scp_pkg::cmd_rec_t     rec,
	input  wire logic             rec_empty,
	output logic                  rec_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  command_done,
	output logic [3:0]            command_id,
	output logic [7:0]            command_value,
	output logic                  value_overflow,
	output logic                  generator_on,
	output logic [7:0]            forward_time,
	output logic [7:0]            reverse_time,
	output logic [7:0]            dead_time_a,
	output logic [7:0]            dead_time_b,
	output logic [7:0]            forward_duty,
	output logic [7:0]            reverse_duty
);
	import scp_pkg::*;

	logic       out_valid_q;
	cmd_rec_t   res_q;
	logic       gen_on_q;
	logic [7:0] fwd_time_q, rev_time_q, dead_a_q, dead_b_q, fwd_duty_q, rev_duty_q;

	assign rec_pop = !rec_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q       <= '0;
			gen_on_q    <= 1'b0;
			fwd_time_q  <= 8'd0;
			rev_time_q  <= 8'd0;
			dead_a_q    <= 8'd0;
			dead_b_q    <= 8'd0;
			fwd_duty_q  <= 8'd0;
			rev_duty_q  <= 8'd0;
		end else if (rec_pop) begin
			out_valid_q <= 1'b1;
			res_q       <= rec;
			if (rec.done) begin
				unique case (rec.id)
					CMD_GEN_OFF:      gen_on_q   <= 1'b0;
					CMD_GEN_ON:       gen_on_q   <= 1'b1;
					CMD_FORWARD_TIME: fwd_time_q <= rec.value;
					CMD_REVERSE_TIME: rev_time_q <= rec.value;
					CMD_DEAD_A:       dead_a_q   <= rec.value;
					CMD_DEAD_B:       dead_b_q   <= rec.value;
					CMD_FORWARD_DUTY: fwd_duty_q <= rec.value;
					CMD_REVERSE_DUTY: rev_duty_q <= rec.value;
					default: begin
					end
				endcase
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign command_done   = res_q.done;
	assign command_id     = res_q.id;
	assign command_value  = res_q.value;
	assign value_overflow = res_q.overflow;
	assign generator_on   = gen_on_q;
	assign forward_time   = fwd_time_q;
	assign reverse_time   = rev_time_q;
	assign dead_time_a    = dead_a_q;
	assign dead_time_b    = dead_b_q;
	assign forward_duty   = fwd_duty_q;
	assign reverse_duty   = rev_duty_q;

endmodule

`default_nettype wire

>>> hdl/serial_command_parser.sv
// Top level of the serial command parser for the pulse generator.
// The input channel takes one received character per request (in_valid, in_stall).
// The output channel returns exactly one result request per character
// (out_valid, out_stall): the command report and the settings after that character.
// A command is 'c', an id digit 1 to 8, up to three decimal digits, then CR or LF.
// An accepted character is registered in the queue, then in the result register, before its result shows.
// Throughput: one character per cycle while in_stall is low; the parser state updates once per accepted character.
// A queue of QUEUE_DEPTH records separates parser and executor, so the input keeps
// flowing while a result waits; in_stall rises only when that queue is full.
// While out_valid and out_stall are both high the result and all settings hold.
// Reset clears the parser to idle, turns the generator off and zeroes all settings.
`default_nettype none

module serial_command_parser #(
	parameter int unsigned QUEUE_DEPTH = scp_pkg::QueueDepthDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] character,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            command_done,
	output logic [3:0]      command_id,
	output logic [7:0]      command_value,
	output logic            value_overflow,
	output logic            generator_on,
	output logic [7:0]      forward_time,
	output logic [7:0]      reverse_time,
	output logic [7:0]      dead_time_a,
	output logic [7:0]      dead_time_b,
	output logic [7:0]      forward_duty,
	output logic [7:0]      reverse_duty
);
	import scp_pkg::*;

	cmd_rec_t push_rec, pop_rec;
	logic     push, pop, q_full, q_empty;

	assign in_stall = q_full;

	scp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (q_full),
		.character(character),
		.rec_push (push),
		.rec      (push_rec)
	);

	scp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_rec),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_rec),
		.empty    (q_empty)
	);

	scp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec           (pop_rec),
		.rec_empty     (q_empty),
		.rec_pop       (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.command_done  (command_done),
		.command_id    (command_id),
		.command_value (command_value),
		.value_overflow(value_overflow),
		.generator_on  (generator_on),
		.forward_time  (forward_time),
		.reverse_time  (reverse_time),
		.dead_time_a   (dead_time_a),
		.dead_time_b   (dead_time_b),
		.forward_duty  (forward_duty),
		.reverse_duty  (reverse_duty)
	);

endmodule

`default_nettype wire

>>> hdl/scp_checker.sv
// Port-level assertions for the serial command parser, bound to the top level.
`default_nettype none

`include "serial_command_parser_assert.svh"

module scp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       command_done,
	input wire logic [3:0] command_id,
	input wire logic [7:0] command_value,
	input wire logic       value_overflow,
	input wire logic       generator_on,
	input wire logic [7:0] forward_time
);
	import scp_pkg::*;

	`SCP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(command_id) && $stable(command_value) && $stable(forward_time),
		"stalled result changed")
	`SCP_ASSERT_IMPLY(a_idle_report, clk, arst_n, out_valid && !command_done,
		command_id == 4'd0 && command_value == 8'd0 && !value_overflow,
		"report fields not cleared without a command")
	`SCP_ASSERT_IMPLY(a_gen_on, clk, arst_n,
		out_valid && command_done && command_id == CMD_GEN_ON, generator_on,
		"generator not enabled by its command")
	`SCP_ASSERT_IMPLY(a_fwd_time, clk, arst_n,
		out_valid && command_done && command_id == CMD_FORWARD_TIME,
		forward_time == command_value, "forward time not loaded with the command value")

endmodule

bind serial_command_parser scp_checker u_scp_checker (.*);

`default_nettype wire

>>> bench/tb_serial_command_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench of the serial command parser: directed and random character streams.

module tb_serial_command_parser;
	import scp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_ID           = 3'd1,
		PH_FIRST_DIGIT  = 3'd2,
		PH_SECOND_DIGIT = 3'd3,
		PH_THIRD_DIGIT  = 3'd4,
		PH_END          = 3'd5
	} parse_phase_t;

	typedef struct {
		logic       done;
		logic [3:0] id;
		logic [7:0] value;
		logic       overflow;
		logic       gen_on;
		logic [7:0] fwd_time;
		logic [7:0] rev_time;
		logic [7:0] dead_a;
		logic [7:0] dead_b;
		logic [7:0] fwd_duty;
		logic [7:0] rev_duty;
	} parser_report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] character = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       command_done;
	logic [3:0] command_id;
	logic [7:0] command_value;
	logic       value_overflow;
	logic       generator_on;
	logic [7:0] forward_time;
	logic [7:0] reverse_time;
	logic [7:0] dead_time_a;
	logic [7:0] dead_time_b;
	logic [7:0] forward_duty;
	logic [7:0] reverse_duty;

	parse_phase_t   phase = PH_IDLE;
	logic [3:0]     cmd_number = '0;
	logic [7:0]     acc_value = '0;
	logic           acc_overflow = 1'b0;
	parser_report_t settings = '{default: '0};
	parser_report_t pending_reports[$];

	bit paced = 1'b1;
	int long_hold = 0;
	int error_count = 0;
	int cycle_count = 0;
	int chars_sent = 0;
	int results_checked = 0;
	int commands_run = 0;
	int wrapped_values = 0;
	int input_stall_cycles = 0;

	serial_command_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.command_done  (command_done),
		.command_id    (command_id),
		.command_value (command_value),
		.value_overflow(value_overflow),
		.generator_on  (generator_on),
		.forward_time  (forward_time),
		.reverse_time  (reverse_time),
		.dead_time_a   (dead_time_a),
		.dead_time_b   (dead_time_b),
		.forward_duty  (forward_duty),
		.reverse_duty  (reverse_duty)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_reports.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_line_end(input logic [7:0] c);
		return c == CH_LF || c == CH_CR;
	endfunction

	function automatic void drop_command();
		phase = PH_IDLE;
		cmd_number = '0;
		acc_value = '0;
		acc_overflow = 1'b0;
	endfunction

	// Advances the parser state by one character and queues the report it should produce.
	function automatic void predict_character(input logic [7:0] c);
		parser_report_t report;
		bit done;
		int sum;
		done = 1'b0;
		case (phase)
			PH_ID: begin
				if (c >= CH_ID_LO && c <= CH_ID_HI) begin
					cmd_number = 4'(c - CH_ZERO);
					acc_value = '0;
					acc_overflow = 1'b0;
					phase = PH_FIRST_DIGIT;
				end else begin
					drop_command();
				end
			end
			PH_FIRST_DIGIT: begin
				if (is_digit(c)) begin
					acc_value = c - CH_ZERO;
					acc_overflow = 1'b0;
					phase = PH_SECOND_DIGIT;
				end else if (is_line_end(c) &&
						(cmd_number == CMD_GEN_OFF || cmd_number == CMD_GEN_ON)) begin
					acc_value = '0;
					acc_overflow = 1'b0;
					done = 1'b1;
				end else begin
					drop_command();
				end
			end
			PH_SECOND_DIGIT, PH_THIRD_DIGIT: begin
				if (is_digit(c)) begin
					sum = int'(acc_value) * 10 + int'(c - CH_ZERO);
					if (sum > 255)
						acc_overflow = 1'b1;
					acc_value = sum[7:0];
					phase = (phase == PH_SECOND_DIGIT) ? PH_THIRD_DIGIT : PH_END;
				end else if (is_line_end(c)) begin
					done = 1'b1;
				end else begin
					drop_command();
				end
			end
			PH_END: begin
				if (is_line_end(c))
					done = 1'b1;
				else
					drop_command();
			end
			default: begin
				phase = (c == CH_START) ? PH_ID : PH_IDLE;
			end
		endcase

		report = settings;
		report.done = 1'b0;
		report.id = '0;
		report.value = '0;
		report.overflow = 1'b0;
		if (done) begin
			case (cmd_number)
				CMD_GEN_OFF:      settings.gen_on = 1'b0;
				CMD_GEN_ON:       settings.gen_on = 1'b1;
				CMD_FORWARD_TIME: settings.fwd_time = acc_value;
				CMD_REVERSE_TIME: settings.rev_time = acc_value;
				CMD_DEAD_A:       settings.dead_a = acc_value;
				CMD_DEAD_B:       settings.dead_b = acc_value;
				CMD_FORWARD_DUTY: settings.fwd_duty = acc_value;
				CMD_REVERSE_DUTY: settings.rev_duty = acc_value;
				default: ;
			endcase
			report = settings;
			report.done = 1'b1;
			report.id = cmd_number;
			report.value = acc_value;
			report.overflow = acc_overflow;
			drop_command();
		end
		pending_reports.push_back(report);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] expected,
			input logic [7:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		parser_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("Result arrived with no character waiting for one.");
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("command_done", 8'(want.done), 8'(command_done));
				check_field("command_id", 8'(want.id), 8'(command_id));
				check_field("command_value", want.value, command_value);
				check_field("value_overflow", 8'(want.overflow), 8'(value_overflow));
				check_field("generator_on", 8'(want.gen_on), 8'(generator_on));
				check_field("forward_time", want.fwd_time, forward_time);
				check_field("reverse_time", want.rev_time, reverse_time);
				check_field("dead_time_a", want.dead_a, dead_time_a);
				check_field("dead_time_b", want.dead_b, dead_time_b);
				check_field("forward_duty", want.fwd_duty, forward_duty);
				check_field("reverse_duty", want.rev_duty, reverse_duty);
				results_checked++;
				if (want.done)
					commands_run++;
				if (want.overflow)
					wrapped_values++;
			end
		end
	end

	// The result side draws a stall length per result; a long hold request takes precedence.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (long_hold != 0) begin
				hold = long_hold;
				long_hold = 0;
			end else begin
				hold = paced ? $urandom_range(0, 7) : 0;
			end
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = paced ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		character <= c;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
			input_stall_cycles++;
		end
		predict_character(c);
		chars_sent++;
	endtask

	task automatic send_command(input logic [7:0] id_char, input int value, input int digits,
			input logic [7:0] term);
		int div;
		send_char(CH_START);
		send_char(id_char);
		div = 1;
		repeat (digits - 1) div *= 10;
		repeat (digits) begin
			send_char(CH_ZERO + 8'((value / div) % 10));
			div /= 10;
		end
		send_char(term);
	endtask

	task automatic send_random_command();
		int id;
		int digits;
		int limit;
		id = $urandom_range(1, 8);
		digits = (id <= 2) ? $urandom_range(0, 3) : $urandom_range(1, 3);
		limit = (digits == 3) ? 999 : (digits == 2) ? 99 : 9;
		send_command(CH_ZERO + 8'(id), $urandom_range(0, limit), digits,
			$urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	task automatic test_directed_commands();
		send_command(CH_ZERO + 8'(CMD_GEN_ON), 0, 0, CH_CR);
		send_command(CH_ZERO + 8'(CMD_GEN_OFF), 0, 0, CH_LF);
		send_command(CH_ZERO + 8'(CMD_FORWARD_TIME), 255, 3, CH_LF);
		send_command(CH_ZERO + 8'(CMD_REVERSE_DUTY), 999, 3, CH_CR);
	endtask

	task automatic test_directed_aborts();
		send_char(CH_START);
		send_char(CH_ZERO + 8'(CMD_REVERSE_TIME));
		send_char(CH_CR);
		send_char(CH_START);
		send_char(CH_NINE);
		send_char(8'h00);
		send_char(8'hFF);
	endtask

	task automatic test_random_stream(input int target);
		int pick;
		while (chars_sent < target) begin
			paced = ($urandom_range(0, 7) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_random_command();
			end else if (pick < 92) begin
				send_char(CH_START);
				send_char(8'($urandom_range(47, 57)));
				repeat ($urandom_range(0, 4)) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
				send_char(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
			end
		end
		paced = 1'b1;
	endtask

	task automatic test_output_hold();
		long_hold = 300;
		repeat (15) send_random_command();
	endtask

	task automatic test_back_to_back();
		paced = 1'b0;
		repeat (10) send_random_command();
		paced = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_commands();
		test_directed_aborts();
		test_back_to_back();
		test_output_hold();
		test_random_stream(1400);
		test_back_to_back();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d characters and checked %0d results: %0d commands ran, %0d wrapped.",
			chars_sent, results_checked, commands_run, wrapped_values);
		$display("Input was held off for %0d cycles, including one long output stall.",
			input_stall_cycles);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
